// ----- rtl/rbws_pkg.sv -----
// Shared types and constants of the ring buffer write splitter.
package rbws_pkg;

	localparam logic [31:0] BASE_ADDRESS = 32'h4000_0000;
	localparam int unsigned WORD_BYTES = 8;
	localparam logic [7:0] FULL_KEEP = 8'hFF;

	// Input item kinds.
	localparam logic KIND_DESC = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// Result item kinds.
	localparam logic OUT_CMD = 1'b0;
	localparam logic OUT_WORD = 1'b1;

	typedef struct packed {
		logic kind;
		logic drop;
		logic [13:0] session;
		logic [15:0] offset;
		logic [15:0] length;
		logic [63:0] data;
		logic [7:0] keep;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic out_kind;
		logic [31:0] cmd_address;
		logic [15:0] cmd_length;
		logic [63:0] out_data;
		logic [7:0] out_keep;
		logic out_last;
		logic end_of_run;
	} result_t;

	// Results of one input item, handed from the step logic to the result buffer.
	typedef struct packed {
		logic [1:0] count;
		result_t [2:0] res;
	} step_out_t;

endpackage

// ----- rtl/rbws_in_if.sv -----
// Input channel interface: descriptors and packet data words.
interface rbws_in_if;
	import rbws_pkg::*;

	logic valid;
	logic ready;
	logic kind;
	logic drop;
	logic [13:0] session;
	logic [15:0] offset;
	logic [15:0] length;
	logic [63:0] data;
	logic [7:0] keep;
	logic last;

	modport source (
		output valid, kind, drop, session, offset, length, data, keep, last,
		input ready
	);
	modport sink (
		input valid, kind, drop, session, offset, length, data, keep, last,
		output ready
	);
endinterface

// ----- rtl/rbws_out_if.sv -----
// Output channel interface: memory write commands and memory data words.
interface rbws_out_if;
	import rbws_pkg::*;

	logic valid;
	logic ready;
	logic out_kind;
	logic [31:0] cmd_address;
	logic [15:0] cmd_length;
	logic [63:0] out_data;
	logic [7:0] out_keep;
	logic out_last;
	logic end_of_run;

	modport source (
		output valid, out_kind, cmd_address, cmd_length, out_data, out_keep, out_last,
		output end_of_run,
		input ready
	);
	modport sink (
		input valid, out_kind, cmd_address, cmd_length, out_data, out_keep, out_last,
		input end_of_run,
		output ready
	);
endinterface

// ----- rtl/ring_buffer_write_splitter_top.sv -----
// Top level of the ring buffer write splitter.
// The block takes a write descriptor followed by the 64-bit data words of a packet and
// turns them into memory write commands and data words for a 64 KiB ring per session:
// the command address is 0x40000000 | session<<16 | offset. A write that runs past the
// ring end is split into two commands; the word that crosses the end is cut and marked
// last, and the rest of the packet is written from offset 0, realigned by the break byte
// count when the break is not on a word boundary (with a trailing residue word where the
// bytes call for it). Words of a dropped packet are consumed without result. A descriptor
// that arrives mid-packet and a data word with no open packet are consumed without result.
// Each input transaction passes an input register and then the step logic, which
// writes its zero to three results into a three-slot result buffer register, from
// which the first result is presented. An item that yields at most one result is
// taken every cycle while the output is ready; an item that yields more results holds
// the input until they have left, and the next item is taken in the cycle its
// predecessor's last result leaves. RING_BYTES must be a power of two between 4096 and
// 1048576; offsets are taken modulo RING_BYTES.
module ring_buffer_write_splitter_top #(
	parameter int unsigned RING_BYTES = 65536
) (
	input logic clk,
	input logic arst_n,
	rbws_in_if.sink ingress,
	rbws_out_if.source egress
);
	import rbws_pkg::*;

	logic valid_s1;
	in_item_t item_s1;
	step_out_t step_out;
	logic can_load;
	logic fire;

	// The registered item moves on whenever the result buffer can take its results; the
	// input register refills in the same cycle, so a new transaction is taken every cycle
	// while the output keeps up.
	assign fire = valid_s1 && can_load;
	assign ingress.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ingress.valid && ingress.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// The payload register needs no reset; it is only looked at while valid_s1 is set.
	always_ff @(posedge clk) begin
		if (ingress.valid && ingress.ready) begin
			item_s1.kind <= ingress.kind;
			item_s1.drop <= ingress.drop;
			item_s1.session <= ingress.session;
			item_s1.offset <= ingress.offset;
			item_s1.length <= ingress.length;
			item_s1.data <= ingress.data;
			item_s1.keep <= ingress.keep;
			item_s1.last <= ingress.last;
		end
	end

	// Packet state, split decision and realignment.
	rbws_step #(
		.RING_BYTES(RING_BYTES)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.step_out(step_out)
	);

	// Results leave one per cycle, in order, under the output handshake.
	rbws_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.load(fire),
		.step_out(step_out),
		.can_load(can_load),
		.egress(egress)
	);

endmodule

// ----- rtl/rbws_step.sv -----
// Packet state and result generation for one registered input item.
module rbws_step #(
	parameter int unsigned RING_BYTES = 65536
) (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input rbws_pkg::in_item_t item,
	output rbws_pkg::step_out_t step_out
);
	import rbws_pkg::*;

	localparam int unsigned OFF_W = $clog2(RING_BYTES);
	localparam int unsigned SUM_W = ((OFF_W > 16) ? OFF_W : 16) + 1;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_FIRST = 2'd1;
	localparam logic [1:0] MODE_PASS = 2'd2;
	localparam logic [1:0] MODE_REALIGN = 2'd3;

	function automatic result_t mk_cmd(input logic [31:0] addr, input logic [15:0] len);
		result_t r;
		r = '0;
		r.out_kind = OUT_CMD;
		r.cmd_address = addr;
		r.cmd_length = len;
		return r;
	endfunction

	function automatic result_t mk_word(input logic [63:0] d, input logic [7:0] k,
			input logic l);
		result_t r;
		r = '0;
		r.out_kind = OUT_WORD;
		r.out_data = d;
		r.out_keep = k;
		r.out_last = l;
		return r;
	endfunction

	function automatic logic [63:0] shr_bytes(input logic [63:0] w, input logic [3:0] n);
		return n[3] ? 64'd0 : (w >> {n[2:0], 3'b000});
	endfunction

	function automatic logic [63:0] shl_bytes(input logic [63:0] w, input logic [3:0] n);
		return n[3] ? 64'd0 : (w << {n[2:0], 3'b000});
	endfunction

	function automatic logic [7:0] keep_of(input logic [15:0] n);
		logic [7:0] k;
		for (int i = 0; i < 8; i++) begin
			k[i] = (n > 16'(i));
		end
		return k;
	endfunction

	function automatic logic [3:0] count_bytes(input logic [7:0] k);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(k[i]);
		end
		return c;
	endfunction

	logic [1:0] mode_q, mode_nxt;
	logic drop_q, drop_nxt;
	logic split_q, split_nxt;
	logic [13:0] sess2_q, sess2_nxt;
	logic [15:0] len2_q, len2_nxt;
	logic [15:0] left_q, left_nxt;
	logic [3:0] shift_q, shift_nxt;
	logic [3:0] resid_q, resid_nxt;
	logic [63:0] prev_q, prev_nxt;

	// Descriptor arithmetic.
	logic [SUM_W-1:0] off_m;
	logic [SUM_W-1:0] off_end;
	logic split_hit;
	logic [15:0] first_len;
	logic [15:0] rest_len;
	logic [31:0] desc_addr;
	logic [31:0] addr2;

	// Break word arithmetic.
	logic [3:0] brk;
	logic brk_aligned;
	logic [3:0] cnt;
	logic [3:0] resid_new;

	// Realignment arithmetic.
	logic [3:0] fill_sh;
	logic [63:0] joined;
	logic [15:0] left_dec;
	logic tail_extra;

	assign off_m = SUM_W'(item.offset) & SUM_W'(RING_BYTES - 1);
	assign off_end = off_m + SUM_W'(item.length);
	assign split_hit = off_end > SUM_W'(RING_BYTES);
	assign first_len = 16'(SUM_W'(RING_BYTES) - off_m);
	assign rest_len = item.length - first_len;
	assign desc_addr = BASE_ADDRESS | {2'b00, item.session, 16'h0000} | 32'(off_m);
	assign addr2 = BASE_ADDRESS | {2'b00, sess2_q, 16'h0000};

	assign brk = left_q[3:0];
	assign brk_aligned = (left_q == 16'(WORD_BYTES));
	assign cnt = count_bytes(item.keep);
	assign resid_new = (cnt > brk) ? (cnt - brk) : 4'd0;

	assign fill_sh = 4'(WORD_BYTES) - {1'b0, shift_q[2:0]};
	assign joined = shift_q[3] ? prev_q
		: (shr_bytes(prev_q, shift_q) | shl_bytes(item.data, fill_sh));
	assign left_dec = (left_q > 16'(WORD_BYTES)) ? (left_q - 16'(WORD_BYTES)) : 16'd0;
	assign tail_extra = (left_q >= 16'(resid_q)) &&
		((left_q - 16'(resid_q)) > 16'(shift_q));

	always_comb begin
		mode_nxt = mode_q;
		drop_nxt = drop_q;
		split_nxt = split_q;
		sess2_nxt = sess2_q;
		len2_nxt = len2_q;
		left_nxt = left_q;
		shift_nxt = shift_q;
		resid_nxt = resid_q;
		prev_nxt = prev_q;
		step_out = '0;

		if (item.kind == KIND_DESC) begin
			if (mode_q == MODE_IDLE) begin
				mode_nxt = MODE_FIRST;
				drop_nxt = item.drop;
				split_nxt = 1'b0;
				if (!item.drop) begin
					if (split_hit) begin
						split_nxt = 1'b1;
						sess2_nxt = item.session;
						len2_nxt = rest_len;
						left_nxt = first_len;
						step_out.res[0] = mk_cmd(desc_addr, first_len);
					end else begin
						left_nxt = item.length;
						step_out.res[0] = mk_cmd(desc_addr, item.length);
					end
					step_out.count = 2'd1;
				end
			end
		end else begin
			case (mode_q)
				MODE_FIRST: begin
					if (drop_q) begin
						if (item.last) begin
							mode_nxt = MODE_IDLE;
						end
					end else if (left_q > 16'(WORD_BYTES)) begin
						left_nxt = left_q - 16'(WORD_BYTES);
						step_out.res[0] = mk_word(item.data, item.keep, item.last);
						step_out.count = 2'd1;
					end else if (!split_q) begin
						step_out.res[0] = mk_word(item.data, item.keep, item.last);
						step_out.count = 2'd1;
						mode_nxt = MODE_IDLE;
					end else begin
						// The word that crosses the ring end closes the first segment.
						step_out.res[0] = mk_word(item.data,
							brk_aligned ? item.keep : keep_of(left_q), 1'b1);
						step_out.res[1] = mk_cmd(addr2, len2_q);
						step_out.count = 2'd2;
						shift_nxt = brk;
						resid_nxt = resid_new;
						prev_nxt = item.data;
						split_nxt = 1'b0;
						left_nxt = len2_q;
						if (brk_aligned) begin
							mode_nxt = MODE_PASS;
						end else if (len2_q > 16'(resid_new)) begin
							mode_nxt = MODE_REALIGN;
						end else begin
							step_out.res[2] = mk_word(shr_bytes(item.data, brk),
								keep_of(len2_q), 1'b1);
							step_out.count = 2'd3;
							mode_nxt = MODE_IDLE;
						end
					end
				end
				MODE_PASS: begin
					step_out.res[0] = mk_word(item.data, item.keep, item.last);
					step_out.count = 2'd1;
					if (item.last) begin
						mode_nxt = MODE_IDLE;
					end
				end
				MODE_REALIGN: begin
					if (item.last) begin
						if (tail_extra) begin
							left_nxt = left_dec;
							step_out.res[0] = mk_word(joined, FULL_KEEP, 1'b0);
							step_out.res[1] = mk_word(shr_bytes(item.data, shift_q),
								keep_of(left_dec), 1'b1);
							step_out.count = 2'd2;
						end else begin
							step_out.res[0] = mk_word(joined, keep_of(left_q), 1'b1);
							step_out.count = 2'd1;
						end
						mode_nxt = MODE_IDLE;
					end else begin
						left_nxt = left_dec;
						step_out.res[0] = mk_word(joined, FULL_KEEP, 1'b0);
						step_out.count = 2'd1;
					end
					prev_nxt = item.data;
				end
				default: begin
				end
			endcase
		end

		case (step_out.count)
			2'd1: step_out.res[0].end_of_run = 1'b1;
			2'd2: step_out.res[1].end_of_run = 1'b1;
			2'd3: step_out.res[2].end_of_run = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			drop_q <= 1'b0;
			split_q <= 1'b0;
			sess2_q <= '0;
			len2_q <= '0;
			left_q <= '0;
			shift_q <= '0;
			resid_q <= '0;
			prev_q <= '0;
		end else if (fire) begin
			mode_q <= mode_nxt;
			drop_q <= drop_nxt;
			split_q <= split_nxt;
			sess2_q <= sess2_nxt;
			len2_q <= len2_nxt;
			left_q <= left_nxt;
			shift_q <= shift_nxt;
			resid_q <= resid_nxt;
			prev_q <= prev_nxt;
		end
	end

	a_split_only_in_first: assert property (@(posedge clk) disable iff (!arst_n)
		split_q |-> (mode_q == MODE_FIRST))
		else $error("split pending outside the first segment");

	a_realign_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_REALIGN) |-> (shift_q != 4'd0) && (shift_q < 4'd8))
		else $error("realignment with an aligned or empty break");

endmodule

// ----- rtl/rbws_out_buf.sv -----
// Three-slot result buffer that hands an item's results out one per cycle while the output is ready.
module rbws_out_buf (
	input logic clk,
	input logic arst_n,
	input logic load,
	input rbws_pkg::step_out_t step_out,
	output logic can_load,
	rbws_out_if.source egress
);
	import rbws_pkg::*;

	result_t [2:0] slot_q;
	logic [1:0] rd_q;
	logic [1:0] rem_q;
	result_t head;

	assign head = slot_q[rd_q];
	assign can_load = (rem_q == 2'd0) || ((rem_q == 2'd1) && egress.ready);

	assign egress.valid = (rem_q != 2'd0);
	assign egress.out_kind = head.out_kind;
	assign egress.cmd_address = head.cmd_address;
	assign egress.cmd_length = head.cmd_length;
	assign egress.out_data = head.out_data;
	assign egress.out_keep = head.out_keep;
	assign egress.out_last = head.out_last;
	assign egress.end_of_run = head.end_of_run;

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= step_out.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			rem_q <= '0;
		end else if (load) begin
			rd_q <= '0;
			rem_q <= step_out.count;
		end else if (egress.valid && egress.ready) begin
			rd_q <= rd_q + 2'd1;
			rem_q <= rem_q - 2'd1;
		end
	end

	a_end_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == 2'd1) |-> egress.end_of_run)
		else $error("final result of a run without end_of_run");

	a_no_early_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q > 2'd1) |-> !egress.end_of_run)
		else $error("end_of_run before the final result of a run");

	a_cmd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(egress.valid && (egress.out_kind == OUT_CMD)) |->
		(egress.out_data == 64'd0) && (egress.out_keep == 8'd0) && !egress.out_last)
		else $error("command result carries data word fields");

endmodule
